[design/skvt_pkg.sv]
// shared codes, widths and the cell command struct for the sorted key/value table
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package skvt_pkg;

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd2;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic compare;
        logic insert;
        logic update;
        logic delete;
    } skvt_cmd_t;

endpackage

`default_nettype wire

[design/skvt_if.sv]
// request and response channel interfaces of the sorted key/value table
// depends on skvt_pkg for the field widths
`default_nettype none

interface skvt_req_if;
    import skvt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] entry_value;
    logic [POS_W-1:0]   position;

    modport source (output valid, kind, key, entry_value, position, input ready);
    modport sink   (input valid, kind, key, entry_value, position, output ready);
endinterface

interface skvt_rsp_if;
    import skvt_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [CNT_W-1:0]   where;
    logic [VALUE_W-1:0] read_value;
    logic [CNT_W-1:0]   entries;
    logic [STAT_W-1:0]  status;

    modport source (output valid, found, where, read_value, entries, status, input ready);
    modport sink   (input valid, found, where, read_value, entries, status, output ready);
endinterface

`default_nettype wire

[design/sorted_key_value_table.sv]
// sorted key/value table built as a row of compare-and-shift cells
// a request steps through the compare, resolve and apply states; apply waits until
// the response register is free; one request at a time: ready returns once apply has
// loaded the response register, which holds its beat while the next request runs
// reset: entry count cleared to zero; slot contents are not cleared, no sweep
// depends on skvt_pkg, skvt_if, skvt_cell and skvt_resolve
`default_nettype none

module sorted_key_value_table #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire               clk,
    input  wire               rst_n,
    skvt_req_if.sink          req,
    skvt_rsp_if.source        rsp
);
    import skvt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RES,
        S_APPLY
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  rsp_valid_reg;

    logic [KIND_W-1:0]     kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  hit_reg;
    logic [CW-1:0]         at_reg;
    logic [VALUE_BITS-1:0] rv_reg;

    logic                  rsp_found_reg;
    logic [CNT_W-1:0]      rsp_where_reg;
    logic [VALUE_W-1:0]    rsp_value_reg;
    logic [CNT_W-1:0]      rsp_entries_reg;
    logic [STAT_W-1:0]     rsp_status_reg;

    logic                  req_fire;
    logic                  out_free;
    logic                  apply_go;
    logic                  is_insert;
    logic                  is_lookup;
    logic                  is_delete;
    logic                  full;
    logic                  pos_ok;
    skvt_cmd_t             cmd;

    logic                  found_next;
    logic [CNT_W-1:0]      where_next;
    logic [VALUE_W-1:0]    value_next;
    logic [STAT_W-1:0]     status_next;

    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   ge_vec;
    logic [CAPACITY-1:0]   eq_vec;
    logic [CAPACITY-1:0]   bnd_vec;

    logic                  res_hit;
    logic [CW-1:0]         res_at;
    logic [VALUE_BITS-1:0] res_value;

    assign req_fire = req.valid & req.ready;
    assign out_free = ~rsp_valid_reg | rsp.ready;
    assign apply_go = (state_reg == S_APPLY) & out_free;

    assign is_insert = (kind_reg == KIND_INSERT);
    assign is_lookup = (kind_reg == KIND_LOOKUP);
    assign is_delete = (kind_reg == KIND_DELETE);
    assign full      = (count_reg == CW'(CAPACITY));
    assign pos_ok    = (PW'(pos_reg) < PW'(count_reg));

    always_comb
    begin
        cmd.compare = (state_reg == S_CMP);
        cmd.insert  = apply_go & is_insert & ~hit_reg & ~full;
        cmd.update  = apply_go & is_insert & hit_reg;
        cmd.delete  = apply_go & is_delete & pos_ok;
    end

    always_comb
    begin
        count_next  = count_reg;
        found_next  = 1'b0;
        where_next  = '0;
        value_next  = '0;
        status_next = STAT_OK;
        if (is_insert)
        begin
            found_next = hit_reg;
            where_next = CNT_W'(at_reg);
            if (!hit_reg)
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
        else if (is_lookup)
        begin
            found_next = hit_reg;
            where_next = CNT_W'(at_reg);
            value_next = hit_reg ? VALUE_W'(rv_reg) : '0;
        end
        else if (is_delete)
        begin
            where_next = CNT_W'(pos_reg);
            if (pos_ok)
            begin
                count_next = count_reg - CW'(1);
            end
            else
            begin
                status_next = STAT_BAD_POS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (apply_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (out_free)
                    begin
                        count_reg <= count_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg  <= req.kind;
            key_reg   <= KEY_BITS'(req.key);
            value_reg <= VALUE_BITS'(req.entry_value);
            pos_reg   <= req.position;
        end
        if (state_reg == S_RES)
        begin
            hit_reg <= res_hit;
            at_reg  <= res_at;
            rv_reg  <= res_value;
        end
        if (apply_go)
        begin
            rsp_found_reg   <= found_next;
            rsp_where_reg   <= where_next;
            rsp_value_reg   <= value_next;
            rsp_entries_reg <= CNT_W'(count_next);
            rsp_status_reg  <= status_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV = (i > 0) ? i - 1 : 0;
        localparam int NEXT = (i < CAPACITY - 1) ? i + 1 : i;

        skvt_cell #(
            .CW         (CW),
            .INDEX      (i),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .count      (count_reg),
            .del_pos    (CW'(pos_reg)),
            .new_key    (key_reg),
            .new_value  (value_reg),
            .prev_ge    ((i > 0) ? ge_vec[PREV] : 1'b0),
            .prev_key   (cell_key[PREV]),
            .prev_value (cell_value[PREV]),
            .next_key   (cell_key[NEXT]),
            .next_value (cell_value[NEXT]),
            .key_q      (cell_key[i]),
            .value_q    (cell_value[i]),
            .ge         (ge_vec[i]),
            .eq         (eq_vec[i]),
            .boundary   (bnd_vec[i])
        );
    end

    skvt_resolve #(
        .CAPACITY   (CAPACITY),
        .CW         (CW),
        .VALUE_BITS (VALUE_BITS)
    ) u_resolve (
        .boundary  (bnd_vec),
        .eq        (eq_vec),
        .values    (cell_value),
        .hit       (res_hit),
        .at        (res_at),
        .hit_value (res_value)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = rsp_found_reg;
    assign rsp.where      = rsp_where_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.entries    = rsp_entries_reg;
    assign rsp.status     = rsp_status_reg;

endmodule

`default_nettype wire

[design/skvt_cell.sv]
// one table slot: holds a key/value pair, compares it against the broadcast key
// and shifts with its neighbors on insert and delete, or takes the new value on update; depends on skvt_pkg
`default_nettype none

module skvt_cell #(
    parameter int CW         = 7,
    parameter int INDEX      = 0,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  skvt_pkg::skvt_cmd_t       cmd,
    input  wire  [CW-1:0]             count,
    input  wire  [CW-1:0]             del_pos,
    input  wire  [KEY_BITS-1:0]       new_key,
    input  wire  [VALUE_BITS-1:0]     new_value,
    input  wire                       prev_ge,
    input  wire  [KEY_BITS-1:0]       prev_key,
    input  wire  [VALUE_BITS-1:0]     prev_value,
    input  wire  [KEY_BITS-1:0]       next_key,
    input  wire  [VALUE_BITS-1:0]     next_value,
    output logic [KEY_BITS-1:0]       key_q,
    output logic [VALUE_BITS-1:0]     value_q,
    output logic                      ge,
    output logic                      eq,
    output logic                      boundary
);
    import skvt_pkg::*;

    localparam logic [CW-1:0] IDX      = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);
    localparam bit            HAS_PREV = (INDEX > 0);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  ge_reg;
    logic                  eq_reg;
    logic                  occupied;

    assign occupied = (IDX < count);
    // first slot at or above the insertion point
    assign boundary = ge_reg & ~prev_ge;

    // ge: slot empty or its key not below the search key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (cmd.compare)
        begin
            ge_reg <= ~occupied | (key_reg >= new_key);
            eq_reg <= occupied & (key_reg == new_key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            if (boundary)
            begin
                key_reg   <= new_key;
                value_reg <= new_value;
            end
            else if (HAS_PREV && ge_reg && IDX <= count)
            begin
                key_reg   <= prev_key;
                value_reg <= prev_value;
            end
        end
        else if (cmd.update)
        begin
            if (eq_reg)
            begin
                value_reg <= new_value;
            end
        end
        else if (cmd.delete)
        begin
            if (IDX >= del_pos && IDX_NEXT < count)
            begin
                key_reg   <= next_key;
                value_reg <= next_value;
            end
        end
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;
    assign ge      = ge_reg;
    assign eq      = eq_reg;

endmodule

`default_nettype wire

[design/skvt_resolve.sv]
// folds the per-cell compare flags into hit, position and read value
// by or-reduction over the row; depends on skvt_pkg
`default_nettype none

module skvt_resolve #(
    parameter int CAPACITY   = 64,
    parameter int CW         = 7,
    parameter int VALUE_BITS = 32
) (
    input  wire  [CAPACITY-1:0]   boundary,
    input  wire  [CAPACITY-1:0]   eq,
    input  wire  [VALUE_BITS-1:0] values [CAPACITY],
    output logic                  hit,
    output logic [CW-1:0]         at,
    output logic [VALUE_BITS-1:0] hit_value
);
    import skvt_pkg::*;

    logic [CW-1:0] at_or;
    logic          any_boundary;

    // boundary and eq are each at most one-hot, so plain or-folding encodes them
    always_comb
    begin
        at_or        = '0;
        any_boundary = 1'b0;
        hit          = 1'b0;
        hit_value    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            at_or        = at_or | (boundary[i] ? CW'(i) : '0);
            any_boundary = any_boundary | boundary[i];
            hit          = hit | eq[i];
            hit_value    = hit_value | (eq[i] ? values[i] : '0);
        end
        // full table with every key below the search key
        at = any_boundary ? at_or : CW'(CAPACITY);
    end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// self-checking bench for the sorted key/value table: directed and random insert,
// lookup and delete beats with a predictor of the sorted table state
// depends on skvt_pkg, skvt_if and sorted_key_value_table
`timescale 1ns / 100ps

module tb_top;
    import skvt_pkg::*;

    localparam int CAP       = 64;
    localparam int CALM_TAIL = 50;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} gen_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] entry_value;
        logic [POS_W-1:0]   position;
    } table_op_t;

    typedef struct packed {
        logic               found;
        logic [CNT_W-1:0]   where;
        logic [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]   entries;
        logic [STAT_W-1:0]  status;
    } table_reply_t;

    typedef struct packed {
        logic [CAP-1:0][KEY_W-1:0]   keys;
        logic [CAP-1:0][VALUE_W-1:0] vals;
        logic [CNT_W-1:0]            count;
    } sorted_pairs_t;

    logic clk = 1'b0;
    logic rst_n;

    skvt_req_if req ();
    skvt_rsp_if rsp ();

    sorted_key_value_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    table_op_t     op_backlog[$];
    table_reply_t  replies_due[$];
    sorted_pairs_t plan;       // state seen by the stimulus generator
    sorted_pairs_t live;       // state advanced on accepted beats
    table_op_t     on_wire;
    int            ops_total = 0;
    int            ops_sent = 0;
    int            replies_seen = 0;
    int            mismatches = 0;
    int            send_gap = 0;
    int            take_gap = 0;
    logic          hold_off = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // applies one operation to the pairs and returns the reply it produces
    function automatic table_reply_t pairs_apply(inout sorted_pairs_t t, input table_op_t op);
        table_reply_t r;
        int           lo;
        int           hi;
        int           mid;
        int           at;
        int           j;
        logic         hit;
        r   = '0;
        lo  = 0;
        hi  = int'(t.count);
        hit = 1'b0;
        at  = 0;
        while (lo < hi && !hit)
        begin
            mid = (lo + hi) / 2;
            if (op.key < t.keys[mid])
                hi = mid;
            else if (op.key > t.keys[mid])
                lo = mid + 1;
            else
            begin
                hit = 1'b1;
                at  = mid;
            end
        end
        if (!hit)
            at = lo;
        case (op.kind)
            KIND_INSERT:
            begin
                if (hit)
                begin
                    t.vals[at] = op.entry_value;
                    r.found    = 1'b1;
                end
                else if (t.count >= CAP)
                    r.status = STAT_FULL;
                else
                begin
                    for (j = int'(t.count); j > at; j--)
                    begin
                        t.keys[j] = t.keys[j-1];
                        t.vals[j] = t.vals[j-1];
                    end
                    t.keys[at] = op.key;
                    t.vals[at] = op.entry_value;
                    t.count    = t.count + 1'b1;
                end
                r.where = CNT_W'(at);
            end
            KIND_LOOKUP:
            begin
                if (hit)
                begin
                    r.found      = 1'b1;
                    r.read_value = t.vals[at];
                end
                r.where = CNT_W'(at);
            end
            KIND_DELETE:
            begin
                r.where = CNT_W'(op.position);
                if (op.position >= t.count)
                    r.status = STAT_BAD_POS;
                else
                begin
                    t.count = t.count - 1'b1;
                    for (j = int'(op.position); j < int'(t.count); j++)
                    begin
                        t.keys[j] = t.keys[j+1];
                        t.vals[j] = t.vals[j+1];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.entries = t.count;
        return r;
    endfunction

    function automatic table_op_t op_of(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                        logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
        table_op_t op;
        op.kind        = kind;
        op.key         = key;
        op.entry_value = val;
        op.position    = pos;
        return op;
    endfunction

    task automatic queue_op(input table_op_t op);
        void'(pairs_apply(plan, op));
        op_backlog.push_back(op);
    endtask

    // random operation shaped by the generator state so that the table fills and drains
    task automatic make_op(input gen_mode_t mode, output table_op_t op);
        int roll;
        int pick;
        int c_new;
        int c_upd;
        int c_look;
        int c_del;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                c_new = 80; c_upd = 88; c_look = 95; c_del = 98;
            end
            MODE_MIXED:
            begin
                c_new = 35; c_upd = 45; c_look = 70; c_del = 96;
            end
            default:
            begin
                c_new = 10; c_upd = 15; c_look = 30; c_del = 97;
            end
        endcase
        op.kind        = KIND_INSERT;
        op.entry_value = $urandom;
        op.position    = POS_W'($urandom_range(0, CAP - 1));
        case ($urandom_range(0, 9))
            0:       op.key = '0;
            1:       op.key = '1;
            2, 3:    op.key = KEY_W'($urandom_range(0, 255));
            default: op.key = $urandom;
        endcase
        if (roll < c_new)
        begin
        end
        else if (roll < c_upd)
        begin
            if (plan.count > 0)
                op.key = plan.keys[$urandom_range(0, plan.count - 1)];
        end
        else if (roll < c_look)
        begin
            op.kind = KIND_LOOKUP;
            if (plan.count > 0 && $urandom_range(0, 1) == 1)
                op.key = plan.keys[$urandom_range(0, plan.count - 1)];
        end
        else if (roll < c_del)
        begin
            op.kind = KIND_DELETE;
            if (plan.count > 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    op.position = '0;
                else if (pick == 1)
                    op.position = POS_W'(plan.count - 1);
                else if (pick == 2 && plan.count < CAP)
                    op.position = POS_W'($urandom_range(plan.count, CAP - 1));
                else
                    op.position = POS_W'($urandom_range(0, plan.count - 1));
            end
        end
        else
        begin
            op.kind = KIND_UNUSED;
            op.key  = $urandom;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req.valid <= 1'b0;
        else
        begin
            if (req.valid && req.ready)
            begin
                replies_due.push_back(pairs_apply(live, on_wire));
                ops_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (send_gap == 0 && op_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 15);
                if (send_gap > 0)
                begin
                    send_gap--;
                    req.valid <= 1'b0;
                end
                else if (op_backlog.size() > 0)
                begin
                    on_wire = op_backlog.pop_front();
                    req.valid       <= 1'b1;
                    req.kind        <= on_wire.kind;
                    req.key         <= on_wire.key;
                    req.entry_value <= on_wire.entry_value;
                    req.position    <= on_wire.position;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // reply monitor and ready driver
    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t got;
        table_reply_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.found      = rsp.found;
                got.where      = rsp.where;
                got.read_value = rsp.read_value;
                got.entries    = rsp.entries;
                got.status     = rsp.status;
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply beat %0d arrived with nothing expected", replies_seen);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.found !== want.found || got.where !== want.where ||
                        got.read_value !== want.read_value || got.entries !== want.entries ||
                        got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("reply beat %0d mismatch", replies_seen);
                            $display("  exp found=%0d where=%0d value=%h entries=%0d status=%0d",
                                     want.found, want.where, want.read_value,
                                     want.entries, want.status);
                            $display("  got found=%0d where=%0d value=%h entries=%0d status=%0d",
                                     got.found, got.where, got.read_value,
                                     got.entries, got.status);
                        end
                    end
                end
                replies_seen++;
            end
            if (hold_off)
                rsp.ready <= 1'b0;
            else
            begin
                if (take_gap == 0 && op_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                    take_gap = $urandom_range(1, 15);
                if (take_gap > 0)
                begin
                    take_gap--;
                    rsp.ready <= 1'b0;
                end
                else
                    rsp.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so that the table backs up into the request channel
    initial
    begin
        wait (rst_n === 1'b1);
        while (ops_sent < 80)
            @(negedge clk);
        hold_off = 1'b1;
        repeat (250) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        table_op_t op;
        int        round;
        int        span;
        gen_mode_t mode;
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.kind        = KIND_INSERT;
        req.key         = '0;
        req.entry_value = '0;
        req.position    = '0;
        rsp.ready       = 1'b0;
        plan            = '0;
        live            = '0;
        on_wire         = '0;

        // empty table: miss and bad positions at both ends
        queue_op(op_of(KIND_LOOKUP, 32'h0, 32'h0, 6'd0));
        queue_op(op_of(KIND_DELETE, 32'h0, 32'h0, 6'd0));
        queue_op(op_of(KIND_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
        // extreme keys and values, landing out of order
        queue_op(op_of(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0));
        queue_op(op_of(KIND_INSERT, 32'h0, 32'h0, 6'd63));
        queue_op(op_of(KIND_INSERT, 32'h8000_0000, 32'h5555_5555, 6'd0));
        queue_op(op_of(KIND_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 6'd0));
        // present key only gets its value replaced
        queue_op(op_of(KIND_INSERT, 32'h0, 32'h1234_5678, 6'd0));
        queue_op(op_of(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 6'd0));
        queue_op(op_of(KIND_LOOKUP, 32'h0, 32'h0, 6'd0));
        queue_op(op_of(KIND_LOOKUP, 32'h4000_0000, 32'h0, 6'd0));
        queue_op(op_of(KIND_LOOKUP, 32'h1, 32'h0, 6'd0));
        queue_op(op_of(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
        // delete last, then one past the end, then the head
        queue_op(op_of(KIND_DELETE, 32'h0, 32'h0, 6'd3));
        queue_op(op_of(KIND_DELETE, 32'h0, 32'h0, 6'd3));
        queue_op(op_of(KIND_DELETE, 32'h0, 32'h0, 6'd0));
        queue_op(op_of(KIND_LOOKUP, 32'h0, 32'h0, 6'd0));
        queue_op(op_of(KIND_INSERT, 32'h1, 32'h0F0F_0F0F, 6'd0));
        queue_op(op_of(KIND_DELETE, 32'h0, 32'h0, 6'd1));

        // rounds cycle through fill, mixed and drain so the table hits full and empty
        round = 0;
        while (op_backlog.size() < 400)
        begin
            mode = gen_mode_t'(round % 3);
            span = (mode == MODE_FILL) ? $urandom_range(90, 110) : $urandom_range(40, 80);
            repeat (span)
            begin
                if (op_backlog.size() < 400)
                begin
                    make_op(mode, op);
                    queue_op(op);
                end
            end
            round++;
        end
        ops_total = op_backlog.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (ops_sent < ops_total)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
